@@ hdl/dowq_pkg.sv @@
package dowq_pkg;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic {
        CFG_MODE    = 1'b0,
        CFG_BURNOUT = 1'b1
    } t_cfg_index;

    typedef enum logic {
        MODE_FIFO = 1'b0,
        MODE_EDF  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [3:0]  id;
        logic [48:0] deadline;
    } t_entry;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] burnout;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic       head_valid;
        logic [3:0] head_id;
        logic [4:0] entry_count;
    } t_result;

endpackage

@@ hdl/dowq_engine.sv @@
module dowq_engine
    import dowq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_opcode     i_op,
    input  logic [3:0]  i_id,
    input  logic [47:0] i_last_start,
    input  logic        i_slot_free,
    output logic        o_rsp_valid,
    output t_result     o_rsp
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic            r_vld, n_vld;
    logic [AW-1:0]   r_vptr, n_vptr;
    logic            r_found, n_found;
    t_opcode         r_op, n_op;
    logic [3:0]      r_id, n_id;
    t_entry          r_carry, n_carry;
    logic [3:0]      r_head, n_head;

    logic            w_we, w_re;
    logic [AW-1:0]   w_waddr, w_raddr;
    t_entry          w_wdata;
    logic            scan_more;
    logic            full;
    t_status         rsp_status;

    assign scan_more = (r_ptr < r_count);
    assign full      = (r_count == CW'(QUEUE_DEPTH));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_op == OP_INSERT && (full || i_cfg.mode == MODE_FIFO)) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!scan_more && !r_vld) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_vld       = 1'b0;
        n_vptr      = r_ptr[AW-1:0];
        n_found     = r_found;
        n_op        = r_op;
        n_id        = r_id;
        n_carry     = r_carry;
        n_head      = r_head;
        w_we        = 1'b0;
        w_waddr     = r_vptr;
        w_wdata     = r_carry;
        w_re        = 1'b0;
        w_raddr     = r_ptr[AW-1:0];
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        rsp_status  = STAT_DONE;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                n_ptr       = '0;
                n_found     = 1'b0;
                if (i_req_valid) begin
                    n_op             = i_op;
                    n_id             = i_id;
                    n_carry.id       = i_id;
                    n_carry.deadline = {1'b0, i_last_start} + {17'd0, i_cfg.burnout};
                end
            end
            S_SCAN: begin
                if (scan_more) begin
                    w_re  = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                    n_vld = 1'b1;
                end
                if (r_vld) begin
                    if (r_op == OP_INSERT) begin
                        if (r_found || r_rdata.deadline > r_carry.deadline) begin
                            w_we    = 1'b1;
                            w_waddr = r_vptr;
                            w_wdata = r_carry;
                            n_carry = r_rdata;
                            n_found = 1'b1;
                        end
                    end else if (r_found) begin
                        w_we    = 1'b1;
                        w_waddr = r_vptr - 1'b1;
                        w_wdata = r_rdata;
                    end else if (r_rdata.id == r_id) begin
                        n_found = 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (i_slot_free) begin
                    o_rsp_valid = 1'b1;
                    if (r_op == OP_INSERT) begin
                        if (full) begin
                            rsp_status = STAT_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_count[AW-1:0];
                            w_wdata = r_carry;
                            n_count = r_count + 1'b1;
                        end
                    end else if (r_found) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        rsp_status = STAT_NOT_FOUND;
                    end
                end
            end
            default: ;
        endcase
        if (w_we && w_waddr == '0) begin
            n_head = w_wdata.id;
        end
    end

    always_comb begin
        o_rsp.status      = rsp_status;
        o_rsp.head_valid  = (n_count != '0);
        o_rsp.head_id     = (n_count != '0) ? n_head : 4'd0;
        o_rsp.entry_count = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
            r_vld   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_vld   <= n_vld;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vptr  <= n_vptr;
        r_op    <= n_op;
        r_id    <= n_id;
        r_carry <= n_carry;
        r_head  <= n_head;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_ptr <= r_count)
        else $error("scan pointer past entry count");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> w_waddr != w_raddr)
        else $error("write and read hit the same entry");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |-> $past(r_state) == S_FINISH)
        else $error("entry count changed outside finish");

endmodule

@@ hdl/deadline_ordered_wait_queue.sv @@
// Deadline-ordered wait queue of requester ids.
// Input channel (i_in_valid/o_in_ready): one beat is an insert or a remove of
// i_member_id; i_last_start is used by inserts only. Output channel
// (o_out_valid/i_out_ready): one beat per input beat, giving the status, the
// head id and the entry count after that operation. Config channel
// (i_cfg_valid/o_cfg_ready, always ready): index 0 selects FIFO or
// earliest-deadline-first ordering, index 1 sets the burnout time.
// Entries live in a single-port-write, registered-read memory. A FIFO insert
// or an insert into a full queue goes from idle straight to the finish state,
// with no scan. A deadline insert or a remove walks the memory one entry per
// cycle in the scan state. In every case the result is registered in the
// output register, and the engine takes the next beat only once it is back
// in idle after the finish state has handed that result over.
// While the receiver stalls, the output register holds one result and the
// engine may take one more beat, then holds that result until the register
// frees. Reset empties the queue and clears both config registers; no
// clearing pass runs over the memory.
module deadline_ordered_wait_queue
    import dowq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [3:0]  i_member_id,
    input  logic [47:0] i_last_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_head_valid,
    output logic [3:0]  o_head_id,
    output logic [4:0]  o_entry_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;
    logic    slot_free;
    logic    rsp_valid;
    t_result rsp;

    assign o_cfg_ready = 1'b1;
    assign slot_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= MODE_FIFO;
            r_cfg.burnout <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MODE:    r_cfg.mode    <= t_mode'(i_cfg_data[0]);
                CFG_BURNOUT: r_cfg.burnout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dowq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_req_valid  (i_in_valid),
        .o_req_ready  (o_in_ready),
        .i_op         (t_opcode'(i_opcode)),
        .i_id         (i_member_id),
        .i_last_start (i_last_start),
        .i_slot_free  (slot_free),
        .o_rsp_valid  (rsp_valid),
        .o_rsp        (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_valid) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_head_valid  = r_out.head_valid;
    assign o_head_id     = r_out.head_id;
    assign o_entry_count = r_out.entry_count;

endmodule
